>>> rtl/gst_pkg.sv
package gst_pkg;

    localparam int GstWires = 64;
    localparam int CntW     = 32;
    localparam int DepthW   = 16;
    localparam int KindW    = 4;
    localparam int MaskW    = 64;
    localparam int WcntW    = 7;

    typedef enum logic [KindW-1:0] {
        GK_T     = 4'd0,
        GK_TS    = 4'd1,
        GK_P     = 4'd2,
        GK_PS    = 4'd3,
        GK_Z     = 4'd4,
        GK_TOF   = 4'd5,
        GK_X     = 4'd6,
        GK_H     = 4'd7,
        GK_OTHER = 4'd8
    } gate_kind_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_SCAN,
        DS_CALC,
        DS_WRITE
    } dstate_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_RUN,
        TS_POST
    } tstate_t;

    typedef struct packed {
        logic             start;
        logic             is_t;
        logic             is_z;
        logic [MaskW-1:0] mask;
    } gst_req_t;

    typedef struct packed {
        logic              done;
        logic [WcntW-1:0]  n_wires;
        logic [WcntW-1:0]  wires_used;
        logic [DepthW-1:0] depth_max;
    } gst_rsp_t;

    function automatic logic [CntW-1:0] sat_add(input logic [CntW-1:0] a,
                                                 input logic [2:0] b);
        logic [CntW:0] s;
        s = {1'b0, a} + (CntW + 1)'(b);
        return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
    endfunction

endpackage

>>> rtl/gst_depth.sv
module gst_depth
    import gst_pkg::*;
#(
    parameter int WIRES = GstWires
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  gst_req_t req,
    output gst_rsp_t rsp
);

    localparam int IW = (WIRES > 1) ? $clog2(WIRES) : 1;
    localparam int CW = $clog2(WIRES + 1);
    localparam logic [IW-1:0] LastIdx = IW'(WIRES - 1);

    dstate_t           state_reg, state_next;
    logic [IW-1:0]     idx_reg;
    logic [WIRES-1:0]  mask_reg;
    logic              is_t_reg;
    logic              is_z_reg;
    logic [CW-1:0]     n_reg;
    logic [WIRES-1:0]  used_reg;
    logic [CW-1:0]     used_cnt_reg;
    logic [WIRES-1:0]  ent_vld_reg;
    logic [DepthW-1:0] max_reg;
    logic [DepthW-1:0] depth_reg;
    logic [DepthW-1:0] best_reg;
    logic [DepthW-1:0] rd_data_reg;
    logic              rd_hit_reg;
    logic              done_reg;
    logic [DepthW-1:0] mem [WIRES];

    logic              last;
    logic [DepthW-1:0] cand;
    logic [DepthW-1:0] max_fin;
    logic [DepthW:0]   sum;
    logic [DepthW:0]   weight;
    logic [DepthW-1:0] d_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        last       = (idx_reg == LastIdx);
        state_next = state_reg;
        unique case (state_reg)
            DS_IDLE:  if (req.start) state_next = DS_SCAN;
            DS_SCAN:  if (last) state_next = DS_CALC;
            DS_CALC:  state_next = DS_WRITE;
            DS_WRITE: if (last) state_next = DS_IDLE;
        endcase
    end

    // running max over the touched wires, one read result per cycle
    always_comb
    begin
        cand    = rd_hit_reg ? rd_data_reg : '0;
        max_fin = (cand > max_reg) ? cand : max_reg;
        if (is_t_reg)
            weight = (DepthW + 1)'(1);
        else if (is_z_reg && (32'(n_reg) >= 32'd3))
            weight = (DepthW + 1)'(3);
        else
            weight = '0;
        sum   = {1'b0, max_fin} + weight;
        d_sat = sum[DepthW] ? {DepthW{1'b1}} : sum[DepthW-1:0];
    end

    // depth store: reads one entry every cycle, writes it in the write pass if touched
    always_ff @(posedge clk)
    begin
        if (state_reg == DS_WRITE && mask_reg[idx_reg])
            mem[idx_reg] <= depth_reg;
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DS_IDLE && req.start)
        begin
            mask_reg <= req.mask[WIRES-1:0];
            is_t_reg <= req.is_t;
            is_z_reg <= req.is_z;
        end
        if (state_reg == DS_CALC)
            depth_reg <= d_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            n_reg        <= '0;
            used_reg     <= '0;
            used_cnt_reg <= '0;
            ent_vld_reg  <= '0;
            max_reg      <= '0;
            best_reg     <= '0;
            rd_hit_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg   <= (state_reg == DS_WRITE) && last;
            rd_hit_reg <= (state_reg == DS_SCAN) && mask_reg[idx_reg] && ent_vld_reg[idx_reg];
            unique case (state_reg)
                DS_IDLE:
                begin
                    if (req.start)
                    begin
                        idx_reg <= '0;
                        n_reg   <= '0;
                        max_reg <= '0;
                    end
                end
                DS_SCAN:
                begin
                    max_reg <= max_fin;
                    n_reg   <= n_reg + CW'(mask_reg[idx_reg]);
                    if (mask_reg[idx_reg] && !used_reg[idx_reg])
                    begin
                        used_reg[idx_reg] <= 1'b1;
                        used_cnt_reg      <= used_cnt_reg + CW'(1);
                    end
                    idx_reg <= last ? '0 : idx_reg + IW'(1);
                end
                DS_CALC:
                begin
                    idx_reg <= '0;
                end
                DS_WRITE:
                begin
                    if (mask_reg[idx_reg])
                    begin
                        ent_vld_reg[idx_reg] <= 1'b1;
                        if (depth_reg > best_reg)
                            best_reg <= depth_reg;
                    end
                    idx_reg <= last ? '0 : idx_reg + IW'(1);
                end
            endcase
        end
    end

    assign rsp.done       = done_reg;
    assign rsp.n_wires    = WcntW'(n_reg);
    assign rsp.wires_used = WcntW'(used_cnt_reg);
    assign rsp.depth_max  = best_reg;

endmodule

>>> rtl/gate_stream_tdepth_stats.sv
// Gate statistics over a stream of quantum gates.
// Input channel s_*: one beat per gate, tdata holds the gate kind and the mask of
// touched wires. Mask bits at or above WIRES are ignored.
// Output channel m_*: one beat per input beat, carrying every running total:
// saturating counts of H, cnot, X, T, P and Z gates, the layer T-depth, the
// number of distinct wires used so far and the critical-path T-depth.
// A result appears once the depth unit has finished the gate and the output slot is
// free; s_tready returns at that same edge, so the next beat can be taken in the
// cycle after, and no new gate is taken before the last result has loaded. The pace
// is set by the per-wire depth store: one scan pass reads each wire's depth through
// its single port to find the maximum, then one write pass stores the new depth to
// every touched wire.
// Reset clears all counters, the open-layer flag, the used-wire set and all wire
// depths (per-entry valid bits, so no clearing pass is needed).
// While the receiver stalls, the finished beat holds on m_*; the next gate is
// still taken and worked on, and its result waits until the held beat is taken.
module gate_stream_tdepth_stats
    import gst_pkg::*;
#(
    parameter int WIRES = GstWires
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [3:0] gate_kind, [67:4] wire_mask, [71:68] zero
    input  logic [71:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] count_h, [63:32] count_cnot, [95:64] count_x, [127:96] count_t,
    // [159:128] count_p, [191:160] count_z, [223:192] depth_by_layers,
    // [230:224] wires_used, [246:231] depth_critical, [247] zero
    output logic [247:0] m_tdata
);

    tstate_t           state_reg, state_next;
    logic [KindW-1:0]  kind_reg;
    logic              out_valid_reg;
    logic [CntW-1:0]   h_reg, cnot_reg, x_reg, t_reg, p_reg, z_reg, layer_reg;
    logic              in_layer_reg;
    logic [WcntW-1:0]  wires_used_reg;
    logic [DepthW-1:0] depth_crit_reg;

    gst_req_t          req;
    gst_rsp_t          rsp;

    logic [KindW-1:0]  in_kind;
    logic              accept;
    logic              slot_free;
    logic              load;

    logic              is_t, is_p, is_z, is_tof, is_x, is_h, z3;
    logic [2:0]        inc_h, inc_cnot, inc_x, inc_t, inc_p, inc_z, inc_layer;
    logic              in_layer_next;

    assign in_kind   = s_tdata[3:0];
    assign s_tready  = (state_reg == TS_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    // hand the gate to the depth unit at the accepting edge
    assign req.start = accept;
    assign req.is_t  = (in_kind == GK_T) || (in_kind == GK_TS);
    assign req.is_z  = (in_kind == GK_Z);
    assign req.mask  = s_tdata[67:4];

    gst_depth #(
        .WIRES (WIRES)
    ) u_depth (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= TS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        unique case (state_reg)
            TS_IDLE: if (accept) state_next = TS_RUN;
            TS_RUN:  if (rsp.done) state_next = TS_POST;
            TS_POST:
            begin
                // wait for the output slot, then publish the new totals
                if (slot_free)
                begin
                    load       = 1'b1;
                    state_next = TS_IDLE;
                end
            end
            default: state_next = TS_IDLE;
        endcase
    end

    // decode the gate kind against the wire count from the scan
    always_comb
    begin
        is_t   = (kind_reg == GK_T) || (kind_reg == GK_TS);
        is_p   = (kind_reg == GK_P) || (kind_reg == GK_PS);
        is_z   = (kind_reg == GK_Z);
        is_tof = (kind_reg == GK_TOF);
        is_x   = (kind_reg == GK_X);
        is_h   = (kind_reg == GK_H);
        z3     = is_z && (rsp.n_wires == WcntW'(3));

        inc_t     = is_t ? 3'd1 : (z3 ? 3'd7 : 3'd0);
        inc_cnot  = z3 ? 3'd7 : ((is_tof && rsp.n_wires == WcntW'(2)) ? 3'd1 : 3'd0);
        inc_x     = ((is_tof && rsp.n_wires != WcntW'(2)) || is_x) ? 3'd1 : 3'd0;
        inc_h     = is_h ? 3'd1 : 3'd0;
        inc_p     = is_p ? 3'd1 : 3'd0;
        inc_z     = (is_z && !z3) ? 3'd1 : 3'd0;
        inc_layer = (is_t && !in_layer_reg) ? 3'd1 : (z3 ? 3'd3 : 3'd0);

        // T opens a layer, P and Z leave it as is, anything else closes it
        if (is_t)
            in_layer_next = 1'b1;
        else if (is_p || is_z)
            in_layer_next = in_layer_reg;
        else
            in_layer_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            kind_reg <= in_kind;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            h_reg          <= '0;
            cnot_reg       <= '0;
            x_reg          <= '0;
            t_reg          <= '0;
            p_reg          <= '0;
            z_reg          <= '0;
            layer_reg      <= '0;
            in_layer_reg   <= 1'b0;
            wires_used_reg <= '0;
            depth_crit_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg  <= 1'b1;
                h_reg          <= sat_add(h_reg, inc_h);
                cnot_reg       <= sat_add(cnot_reg, inc_cnot);
                x_reg          <= sat_add(x_reg, inc_x);
                t_reg          <= sat_add(t_reg, inc_t);
                p_reg          <= sat_add(p_reg, inc_p);
                z_reg          <= sat_add(z_reg, inc_z);
                layer_reg      <= sat_add(layer_reg, inc_layer);
                in_layer_reg   <= in_layer_next;
                wires_used_reg <= rsp.wires_used;
                depth_crit_reg <= rsp.depth_max;
            end
            else if (m_tready)
            begin
                // drop the beat once taken
                out_valid_reg <= 1'b0;
            end
        end
    end

    // totals change only when a new beat loads, so they hold while stalled
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, depth_crit_reg, wires_used_reg, layer_reg, z_reg, p_reg,
                       t_reg, x_reg, cnot_reg, h_reg};

`ifndef ASSERT_OFF
    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == TS_RUN))
        else $error("accepted gate did not start the depth unit");

    a_done_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == TS_RUN))
        else $error("depth unit finished while no gate was in flight");

    a_crit_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        depth_crit_reg >= $past(depth_crit_reg))
        else $error("critical-path depth decreased");

    a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!out_valid_reg || m_tready))
        else $error("result loaded over an untaken beat");
`endif

endmodule

>>> tb/gate_stream_tdepth_stats_test.sv
`timescale 1ns / 1ps

module gate_stream_tdepth_stats_test;

    import gst_pkg::*;

    // Kind codes past GK_OTHER carry no gate of their own; the block treats them like GK_OTHER.
    localparam logic [KindW-1:0] KIND_SPARE_FIRST = 4'd9;
    localparam logic [KindW-1:0] KIND_SPARE_LAST  = 4'd15;

    localparam int RANDOM_GATES = 1850;
    localparam int CALM_GATES   = 150;     // final stretch with no idling on either side
    localparam int DRAIN_AT     = 900;     // sender holds off here until every total is back
    localparam int SETTLE_LEN   = 2 * GstWires + 12;

    // Packed so that a cast of m_tdata[246:0] lines up: count_h sits in the lowest bits.
    typedef struct packed {
        logic [DepthW-1:0] depth_critical;
        logic [WcntW-1:0]  wires_used;
        logic [CntW-1:0]   depth_by_layers;
        logic [CntW-1:0]   count_z;
        logic [CntW-1:0]   count_p;
        logic [CntW-1:0]   count_t;
        logic [CntW-1:0]   count_x;
        logic [CntW-1:0]   count_cnot;
        logic [CntW-1:0]   count_h;
    } gate_totals_t;

    typedef struct {
        logic [KindW-1:0] kind;
        logic [MaskW-1:0] mask;
        bit               typed;
        gate_totals_t     want;
    } gate_row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [247:0] m_tdata;

    // Travel alongside each beat so the scoreboard knows whether the row carries a
    // hand-written expectation.
    logic         beat_typed;
    gate_totals_t beat_want;

    // Shadow copy of the block's statistics state.
    logic [DepthW-1:0] wire_depth_shadow [GstWires];
    logic [CntW-1:0]   h_seen, cnot_seen, x_seen, t_seen, p_seen, z_seen, layers_seen;
    logic              layer_open;
    logic [MaskW-1:0]  wires_seen;

    gate_totals_t pending_totals [$];
    gate_row_t    directed_rows [$];
    int unsigned  mismatch_count = 0;
    bit           calm_tail = 1'b0;

    gate_stream_tdepth_stats dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case a beat never shows up.
    initial
    begin
        #15_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [CntW-1:0] bump_sat(input logic [CntW-1:0] total,
                                                 input int unsigned step);
        logic [CntW:0] sum;
        sum = {1'b0, total} + (CntW + 1)'(step);
        return sum[CntW] ? {CntW{1'b1}} : sum[CntW-1:0];
    endfunction

    // Clear the shadow state the same way reset clears the block.
    task automatic clear_gate_stats();
        for (int i = 0; i < GstWires; i++)
            wire_depth_shadow[i] = '0;
        h_seen      = '0;
        cnot_seen   = '0;
        x_seen      = '0;
        t_seen      = '0;
        p_seen      = '0;
        z_seen      = '0;
        layers_seen = '0;
        layer_open  = 1'b0;
        wires_seen  = '0;
    endtask

    // Fold one gate into the shadow state and return the totals the block must report.
    task automatic advance_gate_stats(input logic [KindW-1:0] kind,
                                      input logic [MaskW-1:0] mask,
                                      output gate_totals_t totals);
        int unsigned       n;
        int unsigned       peak;
        logic [DepthW-1:0] deepest;
        bit                is_t;
        bit                wide_z;
        n      = $countones(mask);
        is_t   = (kind == GK_T) || (kind == GK_TS);
        wide_z = (kind == GK_Z) && (n >= 3);
        wires_seen |= mask;

        if (is_t)
        begin
            t_seen = bump_sat(t_seen, 1);
            if (!layer_open)
            begin
                layer_open  = 1'b1;
                layers_seen = bump_sat(layers_seen, 1);
            end
        end
        else if (kind == GK_P || kind == GK_PS)
            p_seen = bump_sat(p_seen, 1);
        else if (kind == GK_Z && n == 3)
        begin
            // Three-wire Z decomposes into seven T and seven cnot, three layers deep.
            layers_seen = bump_sat(layers_seen, 3);
            t_seen      = bump_sat(t_seen, 7);
            cnot_seen   = bump_sat(cnot_seen, 7);
        end
        else if (kind == GK_Z)
            z_seen = bump_sat(z_seen, 1);
        else
        begin
            layer_open = 1'b0;
            if (kind == GK_TOF && n == 2)
                cnot_seen = bump_sat(cnot_seen, 1);
            else if (kind == GK_TOF || kind == GK_X)
                x_seen = bump_sat(x_seen, 1);
            else if (kind == GK_H)
                h_seen = bump_sat(h_seen, 1);
        end

        // Critical path: deepest touched wire plus the gate's weight, written to all
        // touched wires.
        peak = 0;
        for (int i = 0; i < GstWires; i++)
            if (mask[i] && wire_depth_shadow[i] > peak)
                peak = wire_depth_shadow[i];
        if (is_t)
            peak += 1;
        else if (wide_z)
            peak += 3;
        if (peak > 16'hFFFF)
            peak = 16'hFFFF;
        deepest = '0;
        for (int i = 0; i < GstWires; i++)
        begin
            if (mask[i])
                wire_depth_shadow[i] = DepthW'(peak);
            if (wire_depth_shadow[i] > deepest)
                deepest = wire_depth_shadow[i];
        end

        totals.count_h         = h_seen;
        totals.count_cnot      = cnot_seen;
        totals.count_x         = x_seen;
        totals.count_t         = t_seen;
        totals.count_p         = p_seen;
        totals.count_z         = z_seen;
        totals.depth_by_layers = layers_seen;
        totals.wires_used      = WcntW'($countones(wires_seen));
        totals.depth_critical  = deepest;
    endtask

    task automatic compare_total(input string name, input logic [CntW-1:0] want,
                                 input logic [CntW-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Scoreboard: predict on every input beat, check on every output beat. Both sides
    // are handled in one process so their order within an edge is fixed.
    initial clear_gate_stats();

    always @(posedge clk)
    begin : scoreboard
        gate_totals_t predicted;
        gate_totals_t got;
        gate_totals_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                advance_gate_stats(s_tdata[3:0], s_tdata[67:4], predicted);
                pending_totals = {pending_totals, (beat_typed ? beat_want : predicted)};
            end
            if (m_tvalid && m_tready)
            begin
                got = gate_totals_t'(m_tdata[246:0]);
                if (pending_totals.size() == 0)
                begin
                    $error("output beat with no totals pending");
                    mismatch_count++;
                end
                else
                begin
                    want = pending_totals.pop_front();
                    compare_total("count_h", want.count_h, got.count_h);
                    compare_total("count_cnot", want.count_cnot, got.count_cnot);
                    compare_total("count_x", want.count_x, got.count_x);
                    compare_total("count_t", want.count_t, got.count_t);
                    compare_total("count_p", want.count_p, got.count_p);
                    compare_total("count_z", want.count_z, got.count_z);
                    compare_total("depth_by_layers", want.depth_by_layers,
                                  got.depth_by_layers);
                    compare_total("wires_used", CntW'(want.wires_used),
                                  CntW'(got.wires_used));
                    compare_total("depth_critical", CntW'(want.depth_critical),
                                  CntW'(got.depth_critical));
                end
            end
        end
    end

    // Receiver: short random stalls, now and then a long stretch of steady ready,
    // and no stalls at all once the calm tail starts.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!calm_tail && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat (($urandom_range(0, 9) == 0) ? 400 : $urandom_range(1, 10))
                    @(posedge clk);
            end
        end
    end

    // Mask with exactly n distinct wires drawn from the lowest span wires.
    function automatic logic [MaskW-1:0] few_wires(input int unsigned n,
                                                   input int unsigned span);
        logic [MaskW-1:0] mask;
        mask = '0;
        while ($countones(mask) < n)
            mask[$urandom_range(0, span - 1)] = 1'b1;
        return mask;
    endfunction

    task automatic random_gate(output logic [KindW-1:0] kind, output logic [MaskW-1:0] mask);
        int unsigned pick;
        int unsigned span;
        // A narrow span piles gates onto the same wires so the critical path grows.
        span = $urandom_range(0, 1) ? 8 : GstWires;
        pick = $urandom_range(0, 99);
        mask = few_wires($urandom_range(0, 4), span);
        if (pick < 25)
            kind = $urandom_range(0, 1) ? GK_T : GK_TS;
        else if (pick < 35)
            kind = $urandom_range(0, 1) ? GK_P : GK_PS;
        else if (pick < 50)
        begin
            kind = GK_Z;
            if ($urandom_range(0, 1))
                mask = few_wires(3, span);
        end
        else if (pick < 65)
        begin
            kind = GK_TOF;
            if ($urandom_range(0, 1))
                mask = few_wires(2, span);
        end
        else if (pick < 73)
            kind = GK_X;
        else if (pick < 83)
            kind = GK_H;
        else if (pick < 90)
            kind = GK_OTHER;
        else
            kind = KindW'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        case ($urandom_range(0, 15))
            0:       mask = '0;
            1:       mask = '1;
            2, 3:    mask = {$urandom(), $urandom()};
            default: ;
        endcase
    endtask

    // Present one beat and hold it until the block takes it.
    task automatic send_gate(input logic [KindW-1:0] kind, input logic [MaskW-1:0] mask,
                             input bit typed, input gate_totals_t want);
        s_tvalid   <= 1'b1;
        s_tdata    <= {4'b0000, mask, kind};
        beat_typed <= typed;
        beat_want  <= want;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Drop valid for a while; optionally hold off until every total is back.
    task automatic rest(input int unsigned cycles, input bit drain);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
        if (drain)
            while (pending_totals.size() != 0)
                @(posedge clk);
    endtask

    task automatic play_gate(input logic [KindW-1:0] kind, input logic [MaskW-1:0] mask,
                             input bit typed, input gate_totals_t want);
        send_gate(kind, mask, typed, want);
        if (!calm_tail && $urandom_range(0, 2) == 0)
            rest($urandom_range(1, 6), 1'b0);
    endtask

    task automatic add_row(input logic [KindW-1:0] kind, input logic [MaskW-1:0] mask,
                           input bit typed, input gate_totals_t want);
        gate_row_t row;
        row.kind  = kind;
        row.mask  = mask;
        row.typed = typed;
        row.want  = want;
        directed_rows = {directed_rows, row};
    endtask

    initial
    begin : stimulus
        logic [KindW-1:0] kind;
        logic [MaskW-1:0] mask;
        int unsigned      sent;
        int unsigned      burst;
        int unsigned      guard;
        bit               mid_drained;

        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        beat_typed <= 1'b0;
        beat_want  <= '0;

        // Directed table. Typed rows follow from reset at a glance:
        // {depth_critical, wires_used, layers, z, p, t, x, cnot, h}.
        add_row(GK_H, 64'h0, 1'b1,
                {16'd0, 7'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1});
        add_row(GK_X, '1, 1'b1,
                {16'd0, 7'd64, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd1});
        add_row(GK_T, 64'h8000_0000_0000_0000, 1'b1,
                {16'd1, 7'd64, 32'd1, 32'd0, 32'd0, 32'd1, 32'd1, 32'd0, 32'd1});
        add_row(GK_TS,    64'h8000_0000_0000_0001, 1'b0, '0);
        add_row(GK_P,     64'h1,                   1'b0, '0);  // layer stays open
        add_row(GK_PS,    64'h0,                   1'b0, '0);
        add_row(GK_Z,     64'h7,                   1'b0, '0);  // three-wire Z
        add_row(GK_Z,     64'hF0,                  1'b0, '0);  // wide Z counts as Z and adds depth
        add_row(GK_Z,     64'h300,                 1'b0, '0);
        add_row(GK_Z,     64'h0,                   1'b0, '0);  // empty mask still counts
        add_row(GK_T,     64'h1,                   1'b0, '0);  // same layer continues
        add_row(GK_TOF,   64'h3,                   1'b0, '0);  // two-wire tof is a cnot
        add_row(GK_TOF,   64'h1C,                  1'b0, '0);
        add_row(GK_TOF,   64'h1,                   1'b0, '0);
        add_row(GK_TOF,   64'h0,                   1'b0, '0);
        add_row(GK_OTHER, 64'h8000_0000_0000_0000, 1'b0, '0);
        add_row(KIND_SPARE_LAST,  '1,              1'b0, '0);  // unused code closes layer
        add_row(KIND_SPARE_FIRST, 64'h2,           1'b0, '0);
        add_row(GK_T,     64'h0,                   1'b0, '0);  // new layer, no wire written
        add_row(GK_TS,    '1,                      1'b0, '0);
        add_row(GK_Z,     '1,                      1'b0, '0);
        add_row(GK_H,     64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0);
        add_row(GK_OTHER, 64'h5555_5555_5555_5555, 1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            play_gate(directed_rows[i].kind, directed_rows[i].mask,
                      directed_rows[i].typed, directed_rows[i].want);
        rest(1, 1'b1);

        // Random part: mostly independent gates, with bursts of T gates on shared
        // wires to build layers and a deep critical path.
        sent        = 0;
        mid_drained = 1'b0;
        while (sent < RANDOM_GATES)
        begin
            calm_tail = (sent >= RANDOM_GATES - CALM_GATES);
            if (!mid_drained && sent >= DRAIN_AT)
            begin
                rest(1, 1'b1);
                mid_drained = 1'b1;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(2, 6);
                for (int j = 0; j < burst; j++)
                begin
                    kind = $urandom_range(0, 1) ? GK_T : GK_TS;
                    play_gate(kind, few_wires($urandom_range(1, 3), 8), 1'b0, '0);
                    sent++;
                end
            end
            else
            begin
                random_gate(kind, mask);
                play_gate(kind, mask, 1'b0, '0);
                sent++;
            end
        end
        calm_tail = 1'b1;
        rest(1, 1'b0);

        // Wait out the remaining totals, then watch for strays.
        guard = 0;
        while (pending_totals.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_LEN) @(posedge clk);
        if (pending_totals.size() != 0)
        begin
            $error("%0d expected totals never arrived", pending_totals.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> gate_stream_tdepth_stats.f
rtl/gst_pkg.sv
rtl/gst_depth.sv
rtl/gate_stream_tdepth_stats.sv
tb/gate_stream_tdepth_stats_test.sv
